// ===== rtl/core/call_rate_decimator_defines.svh =====
// Assertion macros for the call rate decimator.
`ifndef CALL_RATE_DECIMATOR_DEFINES_SVH
`define CALL_RATE_DECIMATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CRD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("call_rate_decimator: assertion failed");
`define CRD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("call_rate_decimator: assertion failed");
`else
`define CRD_ASSERT_SAME(label, ante, cons)
`define CRD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/crd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crd_pkg;
   localparam int TID_W   = 32;
   localparam int DEPTH_W = 16;
   localparam int DIV_W   = 4;
   localparam int SUBST_W = 32;

   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_LEAVE = 2'd1;
   localparam logic [1:0] OP_FRAME = 2'd2;

   localparam logic [1:0] REG_ARMED        = 2'd0;
   localparam logic [1:0] REG_RATE_DIVISOR = 2'd1;
   localparam logic [1:0] REG_COUNT_FRAMES = 2'd2;
   localparam logic [1:0] REG_SUBSTITUTE   = 2'd3;

   typedef struct packed {
      logic [1:0]              opcode;
      logic signed [TID_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic                 call_made;
      logic [DEPTH_W-1:0]   nest_depth;
      logic [SUBST_W-1:0]   return_substitute;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/crd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/crd_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crd_mod #(
   parameter int OP_W = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [OP_W-1:0]            operand,
   input  wire logic [crd_pkg::DIV_W-1:0]  divisor,
   output logic                            done,
   output logic      [crd_pkg::DIV_W-1:0]  remainder
);
   localparam int CNT_W = $clog2(OP_W + 1);

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [OP_W-1:0]            shift_ff, shift_in;
   logic [crd_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [crd_pkg::DIV_W-1:0]  div_ff, div_in;
   logic [crd_pkg::DIV_W:0]    trial;

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, shift_ff[OP_W-1]};
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         shift_in = operand;
         rem_in   = '0;
         div_in   = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = crd_pkg::DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[crd_pkg::DIV_W-1:0];
         end
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(OP_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== rtl/core/call_rate_decimator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Frame, unknown, disarmed-enter and pass-all items: strobe in the cycle after the transfer.
// Enter and leave: serial scan of the record RAM, a read and a compare state per record, then
// an update state; an outermost enter adds a bit-serial modulo before the result strobe.
// One item at a time: busy falls in the strobe cycle; the strobe cannot be stalled.
// Sync reset clears counters, config registers and record valid bits; no clearing pass.
`include "call_rate_decimator_defines.svh"
module call_rate_decimator #(
   parameter int COUNT_MODULUS = 840,
   parameter int STALL_LIMIT   = 16,
   parameter int RECORDS       = 4,
   parameter int DIVISOR_LIMIT = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire crd_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output crd_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);
   localparam int CW    = (COUNT_MODULUS > 2) ? $clog2(COUNT_MODULUS) : 1;
   localparam int CIF_W = $clog2(STALL_LIMIT + 1);
   localparam int IW    = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int SW    = $clog2(RECORDS + 1);
   localparam int RW    = crd_pkg::TID_W + crd_pkg::DEPTH_W;
   localparam logic [CW:0] MOD_VAL = (CW + 1)'(COUNT_MODULUS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_MOD    = 3'd4;

   logic                          armed_ff, armed_in;
   logic [crd_pkg::DIV_W-1:0]     rate_ff, rate_in;
   logic                          cframes_ff, cframes_in;
   logic [crd_pkg::SUBST_W-1:0]   subst_ff, subst_in;

   logic [CW-1:0]                 frame_ff, frame_in;
   logic [CW-1:0]                 call_ff, call_in;
   logic [CW-1:0]                 last_ff, last_in;
   logic [CIF_W-1:0]              cif_ff, cif_in;

   logic [2:0]                    state_ff, state_in;
   logic [1:0]                    op_ff, op_in;
   logic [crd_pkg::TID_W-1:0]     tid_ff, tid_in;
   logic [crd_pkg::DIV_W-1:0]     div_ff, div_in;
   logic [SW-1:0]                 scan_ff, scan_in;
   logic                          found_ff, found_in;
   logic [IW-1:0]                 found_idx_ff, found_idx_in;
   logic [crd_pkg::DEPTH_W-1:0]   found_depth_ff, found_depth_in;
   logic                          free_ff, free_in;
   logic [IW-1:0]                 free_idx_ff, free_idx_in;
   logic [crd_pkg::DEPTH_W-1:0]   depth_ff, depth_in;

   logic [RECORDS-1:0]            valid_ff, valid_in;
   logic                          rd_valid_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   crd_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          accept;
   logic                          cfg_write;
   logic [crd_pkg::DIV_W-1:0]     div_clamped;
   logic [crd_pkg::TID_W-1:0]     tid_mapped;
   logic [IW-1:0]                 rd_addr;
   logic [RW-1:0]                 rd_data;
   logic [crd_pkg::TID_W-1:0]     rec_owner;
   logic [crd_pkg::DEPTH_W-1:0]   rec_depth;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   logic [RW-1:0]                 wr_data;
   logic [crd_pkg::DEPTH_W-1:0]   dep_inc;
   logic [crd_pkg::DEPTH_W-1:0]   dep_dec;
   logic                          mod_start;
   logic [CW-1:0]                 mod_operand;
   logic                          mod_done;
   logic [crd_pkg::DIV_W-1:0]     mod_rem;

   function automatic logic [CW-1:0] wrap_next(input logic [CW-1:0] v);
      logic [CW:0] n;
      n = {1'b0, v} + 1'b1;
      return (n >= MOD_VAL) ? '0 : n[CW-1:0];
   endfunction

   assign accept     = start && !busy;
   assign cfg_write  = psel && penable && pwrite;
   assign pready     = 1'b1;
   assign tid_mapped = (req_data.thread_id == '0) ? '1 : req_data.thread_id;
   assign div_clamped = ({4'd0, rate_ff} > 8'(DIVISOR_LIMIT)) ?
                        crd_pkg::DIV_W'(DIVISOR_LIMIT) : rate_ff;
   assign rd_addr    = scan_ff[IW-1:0];
   assign rec_owner  = rd_valid_ff ? rd_data[RW-1:crd_pkg::DEPTH_W] : '0;
   assign rec_depth  = rd_valid_ff ? rd_data[crd_pkg::DEPTH_W-1:0] : '0;
   assign dep_inc    = (found_depth_ff == '1) ? found_depth_ff : found_depth_ff + 1'b1;
   assign dep_dec    = (found_depth_ff == '0) ? '0 : found_depth_ff - 1'b1;

   always_comb begin
      case (paddr[3:2])
         crd_pkg::REG_ARMED:        prdata = {31'd0, armed_ff};
         crd_pkg::REG_RATE_DIVISOR: prdata = {28'd0, rate_ff};
         crd_pkg::REG_COUNT_FRAMES: prdata = {31'd0, cframes_ff};
         crd_pkg::REG_SUBSTITUTE:   prdata = subst_ff;
         default:                   prdata = '0;
      endcase
   end

   always_comb begin
      armed_in   = armed_ff;
      rate_in    = rate_ff;
      cframes_in = cframes_ff;
      subst_in   = subst_ff;
      if (cfg_write) begin
         case (paddr[3:2])
            crd_pkg::REG_ARMED:        armed_in   = pwdata[0];
            crd_pkg::REG_RATE_DIVISOR: rate_in    = pwdata[crd_pkg::DIV_W-1:0];
            crd_pkg::REG_COUNT_FRAMES: cframes_in = pwdata[0];
            crd_pkg::REG_SUBSTITUTE:   subst_in   = pwdata;
            default:                   armed_in   = armed_ff;
         endcase
      end
   end

   always_comb begin
      frame_in       = frame_ff;
      call_in        = call_ff;
      last_in        = last_ff;
      cif_in         = cif_ff;
      state_in       = state_ff;
      op_in          = op_ff;
      tid_in         = tid_ff;
      div_in         = div_ff;
      scan_in        = scan_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_depth_in = found_depth_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      depth_in       = depth_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = found_idx_ff;
      wr_data        = {tid_ff, dep_inc};
      mod_start      = 1'b0;
      mod_operand    = call_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_data.opcode;
               tid_in   = tid_mapped;
               div_in   = div_clamped;
               scan_in  = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               rsp_in   = '0;
               case (req_data.opcode)
                  crd_pkg::OP_ENTER: begin
                     if (!armed_ff) begin
                        rsp_in.return_substitute = subst_ff;
                        rsp_valid_in = 1'b1;
                     end else if (div_clamped <= 4'd1) begin
                        rsp_in.call_made = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  crd_pkg::OP_LEAVE: begin
                     state_in = S_READ;
                  end
                  crd_pkg::OP_FRAME: begin
                     frame_in     = wrap_next(frame_ff);
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!found_ff && rec_owner == tid_ff) begin
               found_in       = 1'b1;
               found_idx_in   = scan_ff[IW-1:0];
               found_depth_in = rec_depth;
            end
            if (!free_ff && rec_owner == '0) begin
               free_in     = 1'b1;
               free_idx_in = scan_ff[IW-1:0];
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == SW'(RECORDS - 1)) begin
               state_in = S_UPDATE;
            end else begin
               state_in = S_READ;
            end
         end
         S_UPDATE: begin
            rsp_in = '0;
            if (op_ff == crd_pkg::OP_LEAVE) begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_data = {((dep_dec == '0) ? '0 : tid_ff), dep_dec};
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               if (found_ff) begin
                  wr_en    = 1'b1;
                  depth_in = dep_inc;
               end else if (free_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = free_idx_ff;
                  wr_data  = {tid_ff, crd_pkg::DEPTH_W'(1)};
                  depth_in = crd_pkg::DEPTH_W'(1);
               end else begin
                  depth_in = crd_pkg::DEPTH_W'(1);
               end
               if (found_ff && dep_inc > crd_pkg::DEPTH_W'(1)) begin
                  rsp_in.call_made  = 1'b1;
                  rsp_in.nest_depth = dep_inc;
                  rsp_valid_in      = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  call_in   = wrap_next(call_ff);
                  mod_start = 1'b1;
                  if (cframes_ff) begin
                     if (frame_ff != last_ff) begin
                        last_in     = frame_ff;
                        cif_in      = '0;
                        mod_operand = frame_ff;
                     end else if (cif_ff < CIF_W'(STALL_LIMIT)) begin
                        cif_in      = cif_ff + 1'b1;
                        mod_operand = frame_ff;
                     end
                  end
                  state_in = S_MOD;
               end
            end
            if (wr_en) begin
               valid_in[wr_addr] = 1'b1;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               rsp_in.nest_depth = depth_ff;
               if (mod_rem == '0) begin
                  rsp_in.call_made         = 1'b1;
                  rsp_in.return_substitute = '0;
               end else begin
                  rsp_in.call_made         = 1'b0;
                  rsp_in.return_substitute = subst_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         rate_ff      <= '0;
         cframes_ff   <= 1'b0;
         subst_ff     <= '0;
         frame_ff     <= '0;
         call_ff      <= '0;
         last_ff      <= '0;
         cif_ff       <= '0;
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         rate_ff      <= rate_in;
         cframes_ff   <= cframes_in;
         subst_ff     <= subst_in;
         frame_ff     <= frame_in;
         call_ff      <= call_in;
         last_ff      <= last_in;
         cif_ff       <= cif_in;
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= valid_ff[rd_addr];
      end
      op_ff          <= op_in;
      tid_ff         <= tid_in;
      div_ff         <= div_in;
      found_idx_ff   <= found_idx_in;
      found_depth_ff <= found_depth_in;
      free_idx_ff    <= free_idx_in;
      depth_ff       <= depth_in;
      rsp_ff         <= rsp_in;
   end

   crd_ram #(
      .WIDTH (RW),
      .DEPTH (RECORDS)
   ) u_records (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   crd_mod #(
      .OP_W (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .operand   (mod_operand),
      .divisor   (div_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CRD_ASSERT_SAME(a_rsp_has_cause, rsp_valid, $past(busy || start))
   `CRD_ASSERT_NEXT(a_accept_splits, accept, rsp_valid != busy)
   `CRD_ASSERT_NEXT(a_mod_done_reports, (state_ff == S_MOD) && mod_done, rsp_valid && !busy)
endmodule
`default_nettype wire
